### design/mra_pkg.sv
// Shared types and constants for the mapped region allocator.
package mra_pkg;

  localparam logic [39:0] MapLo  = 40'h00_0010_0000;
  localparam logic [39:0] MapHi  = 40'h3F_FFFF_B000;
  localparam logic [39:0] SigLen = 40'h00_0000_1000;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    FK_INSTR = 2'd0,
    FK_LOAD  = 2'd1,
    FK_STORE = 2'd2,
    FK_OTHER = 2'd3
  } fault_kind_e;

  typedef enum logic [2:0] {
    CFG_CODE_START = 3'd0,
    CFG_CODE_SIZE  = 3'd1,
    CFG_STACK_START = 3'd2,
    CFG_STACK_SIZE = 3'd3,
    CFG_SIG_START  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HINT_OBS,
    ST_HINT_REG,
    ST_SCAN_OBS,
    ST_SCAN_REG,
    ST_QUERY,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [38:0] hint_address;
    logic [38:0] length;
    logic [3:0]  protection;
    logic [15:0] req_flags;
    logic [37:0] fault_address;
    logic [1:0]  fault_kind;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [37:0] mapped_address;
    logic [3:0]  slot_used;
    logic        fault_allowed;
    logic        perm_read;
    logic        perm_write;
    logic        perm_exec;
  } rsp_t;

  // One obstacle for the overlap test against the candidate window.
  typedef struct packed {
    logic        en;
    logic [39:0] lo;
    logic [39:0] len;
  } obs_t;

  function automatic logic [39:0] page_up(input logic [39:0] v);
    logic [39:0] s;
    s = v + 40'hFFF;
    return {s[39:12], 12'h000};
  endfunction

endpackage

### design/mra_overlap.sv
// Shared overlap unit: tests one obstacle against the candidate window.
module mra_overlap (
  input  logic [39:0]   cand_i,
  input  logic [39:0]   len_i,
  input  mra_pkg::obs_t obs_i,
  output logic          hit_o,
  output logic [39:0]   end_o
);
  logic [39:0] cand_hi;
  assign cand_hi = cand_i + len_i;
  assign end_o   = obs_i.lo + obs_i.len;
  assign hit_o   = obs_i.en && (cand_i < end_o) && (obs_i.lo < cand_hi);
endmodule

### design/mmap_region_allocator.sv
// Top level: first-fit mapped region allocator with sequenced obstacle scan.
// Each map candidate gets a bound check, then the three fixed ranges, then one
// region per cycle through a single overlap unit. One command at a time;
// busy holds meanwhile. Reset empties the region table and loads register defaults.
// The result strobe lasts one cycle; the receiver cannot stall it.
module mmap_region_allocator #(
  parameter int REGION_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mra_pkg::req_t req_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [38:0]   cfg_data_i,
  output logic          done_o,
  output mra_pkg::rsp_t rsp_o
);
  localparam int SW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  // configuration
  logic [37:0] code_start_q, stack_start_q, sig_start_q;
  logic [38:0] code_size_q, stack_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_start_q  <= '0;
      code_size_q   <= '0;
      stack_start_q <= 38'h3F_FFFF_C000;
      stack_size_q  <= 39'h4000;
      sig_start_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mra_pkg::CFG_CODE_START:  code_start_q  <= cfg_data_i[37:0];
        mra_pkg::CFG_CODE_SIZE:   code_size_q   <= cfg_data_i;
        mra_pkg::CFG_STACK_START: stack_start_q <= cfg_data_i[37:0];
        mra_pkg::CFG_STACK_SIZE:  stack_size_q  <= cfg_data_i;
        mra_pkg::CFG_SIG_START:   sig_start_q   <= cfg_data_i[37:0];
        default: ;
      endcase
    end
  end

  // region table: valid bits in flops, payload in plain registers
  logic [REGION_SLOTS-1:0] valid_q;
  logic [37:0] rstart_q [REGION_SLOTS];
  logic [38:0] rsize_q  [REGION_SLOTS];
  logic [2:0]  rprot_q  [REGION_SLOTS];

  mra_pkg::state_e state_q, state_d;
  mra_pkg::req_t   req_q;
  mra_pkg::rsp_t   rsp_q, rsp_d;
  logic [39:0] cand_q, cand_d, from_q, from_d, len_q, len_d, jump_q, jump_d;
  logic        wrap_q, wrap_d;
  logic [1:0]  oidx_q, oidx_d;
  logic [SW-1:0] ridx_q, ridx_d;
  logic [SW-1:0] slot_q, slot_d;
  logic        done_q, done_d;
  logic        do_write, do_clear;

  // lowest free slot
  logic          free_found;
  logic [SW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  // obstacle mux into the shared unit: fixed ranges first, then region slots
  mra_pkg::obs_t obs;
  logic          ov_hit;
  logic [39:0]   ov_end;
  always_comb begin
    obs = '0;
    if (state_q == mra_pkg::ST_SCAN_OBS && oidx_q != 2'd3) begin
      case (oidx_q)
        2'd0: obs = '{en: code_size_q != '0, lo: {2'b0, code_start_q},
                      len: {1'b0, code_size_q}};
        2'd1: obs = '{en: stack_size_q != '0, lo: {2'b0, stack_start_q},
                      len: {1'b0, stack_size_q}};
        default: obs = '{en: sig_start_q != '0, lo: {2'b0, sig_start_q},
                         len: mra_pkg::SigLen};
      endcase
    end else begin
      obs = '{en: valid_q[ridx_q], lo: {2'b0, rstart_q[ridx_q]},
              len: {1'b0, rsize_q[ridx_q]}};
    end
  end

  mra_overlap u_ovl (
    .cand_i (cand_q),
    .len_i  (len_q),
    .obs_i  (obs),
    .hit_o  (ov_hit),
    .end_o  (ov_end)
  );

  // query compare for one slot
  logic [39:0] q_addr;
  logic        q_hit;
  logic [2:0]  q_prot;
  logic        q_need;
  assign q_addr = {2'b0, req_q.fault_address};
  assign q_hit  = valid_q[ridx_q] && (q_addr >= {2'b0, rstart_q[ridx_q]}) &&
                  (q_addr < ov_end);
  assign q_prot = rprot_q[ridx_q];
  always_comb begin
    case (req_q.fault_kind)
      mra_pkg::FK_INSTR: q_need = q_prot[2];
      mra_pkg::FK_LOAD:  q_need = q_prot[0];
      mra_pkg::FK_STORE: q_need = q_prot[1];
      default:           q_need = 1'b0;
    endcase
  end

  logic        stack_hit;
  assign stack_hit = (stack_size_q != '0) && (q_addr >= {2'b0, stack_start_q}) &&
                     (q_addr < ({2'b0, stack_start_q} + {1'b0, stack_size_q})) &&
                     (req_q.fault_kind == mra_pkg::FK_LOAD ||
                      req_q.fault_kind == mra_pkg::FK_STORE);

  // sequencer
  always_comb begin
    logic [39:0] hint, plen, from;
    logic        cand_ok;
    state_d  = state_q;
    rsp_d    = rsp_q;
    cand_d   = cand_q;
    from_d   = from_q;
    len_d    = len_q;
    jump_d   = jump_q;
    wrap_d   = wrap_q;
    oidx_d   = oidx_q;
    ridx_d   = ridx_q;
    slot_d   = slot_q;
    done_d   = 1'b0;
    do_write = 1'b0;
    do_clear = 1'b0;
    hint     = {1'b0, req_q.hint_address};
    plen     = mra_pkg::page_up({1'b0, req_q.length});
    from     = (hint != '0) ? mra_pkg::page_up(hint) : mra_pkg::MapLo;
    if (from < mra_pkg::MapLo) from = mra_pkg::MapLo;
    cand_ok  = 1'b0;
    case (state_q)
      mra_pkg::ST_IDLE: begin
        rsp_d = '0;
        if (start) begin
          state_d = mra_pkg::ST_DONE;
          case (req_i.command)
            mra_pkg::CMD_MAP:   state_d = mra_pkg::ST_HINT_OBS;
            mra_pkg::CMD_QUERY: begin
              state_d = mra_pkg::ST_QUERY;
              ridx_d  = '0;
              rsp_d.ok = 1'b1;
            end
            mra_pkg::CMD_CLEAR: begin
              do_clear = 1'b1;
              rsp_d.ok = 1'b1;
            end
            default: ;
          endcase
        end
      end
      mra_pkg::ST_HINT_OBS: begin
        // legality checks, hint setup
        if ((req_q.req_flags & ~16'h8020) != '0 || !req_q.req_flags[5] ||
            req_q.protection[3] ||
            {1'b0, req_q.length} > (mra_pkg::MapHi - mra_pkg::MapLo) ||
            plen == '0 || !free_found) begin
          state_d = mra_pkg::ST_DONE;
        end else begin
          len_d  = plen;
          slot_d = free_slot;
          from_d = from;
          wrap_d = 1'b0;
          oidx_d = '0;
          ridx_d = '0;
          if (hint != '0 && hint[11:0] == '0 && hint + plen <= mra_pkg::MapHi) begin
            cand_d  = hint;
            state_d = mra_pkg::ST_HINT_REG;
          end else begin
            cand_d  = from;
            state_d = mra_pkg::ST_SCAN_REG;
          end
        end
      end
      mra_pkg::ST_HINT_REG, mra_pkg::ST_SCAN_REG: begin
        // entry for a candidate: check bounds (scan only), then fixed ranges in SCAN_OBS
        if (state_q == mra_pkg::ST_SCAN_REG &&
            !(cand_q + len_q <= mra_pkg::MapHi && (!wrap_q || cand_q < from_q))) begin
          if (!wrap_q) begin
            wrap_d = 1'b1;
            cand_d = mra_pkg::MapLo;
          end else begin
            state_d = mra_pkg::ST_DONE;
          end
        end else begin
          wrap_d  = wrap_q;
          oidx_d  = '0;
          ridx_d  = '0;
          jump_d  = '0;
          state_d = mra_pkg::ST_SCAN_OBS;
          if (state_q == mra_pkg::ST_HINT_REG) wrap_d = wrap_q;
          // all-ones jump marks the hint attempt
          if (state_q == mra_pkg::ST_HINT_REG) jump_d = 40'hFF_FFFF_FFFF;
        end
      end
      mra_pkg::ST_SCAN_OBS: begin
        // walk code, stack, signal stack, then regions; jump_q all-ones flags hint try
        if (oidx_q != 2'd3) begin
          if (ov_hit) begin
            if (jump_q == 40'hFF_FFFF_FFFF) begin
              cand_d  = from_q;
              state_d = mra_pkg::ST_SCAN_REG;
            end else begin
              jump_d  = ov_end;
              cand_d  = mra_pkg::page_up(ov_end);
              state_d = mra_pkg::ST_SCAN_REG;
            end
          end else begin
            oidx_d = oidx_q + 2'd1;
          end
        end else begin
          if (ov_hit) begin
            if (jump_q == 40'hFF_FFFF_FFFF) cand_d = from_q;
            else cand_d = mra_pkg::page_up(ov_end);
            state_d = mra_pkg::ST_SCAN_REG;
          end else if (ridx_q == SW'(REGION_SLOTS - 1)) begin
            cand_ok = 1'b1;
          end else begin
            ridx_d = ridx_q + SW'(1);
          end
        end
        if (cand_ok) begin
          do_write = 1'b1;
          rsp_d.ok = 1'b1;
          rsp_d.mapped_address = cand_q[37:0];
          rsp_d.slot_used = 4'(slot_q);
          state_d = mra_pkg::ST_DONE;
        end
      end
      mra_pkg::ST_QUERY: begin
        if (q_hit) begin
          rsp_d.fault_allowed = (q_prot != '0) && q_need;
          rsp_d.perm_read  = q_prot[0] | q_prot[1];
          rsp_d.perm_write = q_prot[1];
          rsp_d.perm_exec  = q_prot[2];
          state_d = mra_pkg::ST_DONE;
        end else if (ridx_q == SW'(REGION_SLOTS - 1)) begin
          rsp_d.fault_allowed = stack_hit;
          rsp_d.perm_read  = stack_hit;
          rsp_d.perm_write = stack_hit;
          state_d = mra_pkg::ST_DONE;
        end else begin
          ridx_d = ridx_q + SW'(1);
        end
      end
      mra_pkg::ST_DONE: begin
        done_d  = 1'b1;
        state_d = mra_pkg::ST_IDLE;
      end
      default: state_d = mra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mra_pkg::ST_IDLE;
      valid_q <= '0;
      done_q  <= 1'b0;
      oidx_q  <= '0;
      ridx_q  <= '0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      oidx_q  <= oidx_d;
      ridx_q  <= ridx_d;
      wrap_q  <= wrap_d;
      if (do_clear) valid_q <= '0;
      else if (do_write) valid_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mra_pkg::ST_IDLE && start) req_q <= req_i;
    rsp_q  <= rsp_d;
    cand_q <= cand_d;
    from_q <= from_d;
    len_q  <= len_d;
    jump_q <= jump_d;
    slot_q <= slot_d;
    if (do_write) begin
      rstart_q[slot_q] <= cand_q[37:0];
      rsize_q[slot_q]  <= len_q[38:0];
      rprot_q[slot_q]  <= req_q.protection[2:0];
    end
  end

  assign busy   = (state_q != mra_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = done_q ? rsp_q : '0;

endmodule
